// ===== rtl/core/motion_signal_light_controller_unit_defines.svh =====
// ---------------------------------------------------------------------------
// motion signal light controller assertion macros
// concurrent checks on the rising edge of i_clk, off while reset is low
// ---------------------------------------------------------------------------
`ifndef MOTION_SIGNAL_LIGHT_CONTROLLER_UNIT_DEFINES_SVH
`define MOTION_SIGNAL_LIGHT_CONTROLLER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MSL_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("msl check failed");
`define MSL_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
`else
`define MSL_ASSERT(label, prop)
`define MSL_ASSERT_MSG(label, prop, msg)
`endif

`endif

// ===== rtl/core/msl_pkg.sv =====
// ---------------------------------------------------------------------------
// msl_pkg
// shared widths, constants and types of the motion signal light controller
// ---------------------------------------------------------------------------
`default_nettype none

package msl_pkg;

    localparam int ACC_W      = 16;
    localparam int TURN_W     = 15;
    localparam int CNT_W      = 16;
    localparam int LVL_W      = 8;
    localparam int COLOUR_W   = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0]    CNT_SAT   = '1;
    localparam logic [LVL_W-1:0]    RAMP_STEP = 8'd15;
    localparam logic [LVL_W-1:0]    LVL_MAX   = 8'd255;
    localparam logic [COLOUR_W-1:0] ORANGE    = 24'hFF4100;

    localparam logic [TURN_W-1:0]       TURN_RST   = 15'd10000;
    localparam logic signed [ACC_W-1:0] BRAKE_RST  = 16'sd10000;
    localparam logic [CNT_W-1:0]        SAMPLE_RST = 16'd50;
    localparam logic [CNT_W-1:0]        BLINK_RST  = 16'd500;
    localparam logic [CNT_W-1:0]        RAMP_RST   = 16'd10;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TURN   = 3'd0,
        REG_BRAKE  = 3'd1,
        REG_SAMPLE = 3'd2,
        REG_BLINK  = 3'd3,
        REG_RAMP   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [TURN_W-1:0]       turn_thr;
        logic signed [ACC_W-1:0] brake_thr;
        logic [CNT_W-1:0]        sample_per;
        logic [CNT_W-1:0]        blink_per;
        logic [CNT_W-1:0]        ramp_per;
    } t_cfg;

    typedef struct packed {
        logic [LVL_W-1:0] led_red;
        logic [LVL_W-1:0] led_green;
        logic [LVL_W-1:0] led_blue;
        logic             front_light;
        logic             is_turning;
        logic             is_braking;
    } t_result;

    // saturating tick counter
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_SAT) ? CNT_SAT : c + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/msl_in_if.sv =====
// ---------------------------------------------------------------------------
// msl_in_if
// request channel carrying one millisecond tick of sensor data
// ---------------------------------------------------------------------------
`default_nettype none

interface msl_in_if;

    logic                                valid;
    logic                                ready;
    logic signed [msl_pkg::ACC_W-1:0]    accel_x;
    logic signed [msl_pkg::ACC_W-1:0]    accel_y;
    logic                                button_pressed;

    modport source (output valid, output accel_x, output accel_y,
                    output button_pressed, input ready);
    modport sink   (input valid, input accel_x, input accel_y,
                    input button_pressed, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/msl_out_if.sv =====
// ---------------------------------------------------------------------------
// msl_out_if
// result channel carrying the light state after one tick
// ---------------------------------------------------------------------------
`default_nettype none

interface msl_out_if;

    logic                        valid;
    logic                        ready;
    logic [msl_pkg::LVL_W-1:0]   led_red;
    logic [msl_pkg::LVL_W-1:0]   led_green;
    logic [msl_pkg::LVL_W-1:0]   led_blue;
    logic                        front_light;
    logic                        is_turning;
    logic                        is_braking;

    modport source (output valid, output led_red, output led_green, output led_blue,
                    output front_light, output is_turning, output is_braking,
                    input ready);
    modport sink   (input valid, input led_red, input led_green, input led_blue,
                    input front_light, input is_turning, input is_braking,
                    output ready);

endinterface

`default_nettype wire

// ===== rtl/core/msl_window.sv =====
// ---------------------------------------------------------------------------
// msl_window
// sample timer and moving sums over the last WINDOW samples of x and y
// ---------------------------------------------------------------------------
`default_nettype none

module msl_window #(
    parameter int WINDOW = 20
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_step,
    input  wire msl_pkg::t_cfg                                 i_cfg,
    input  wire logic signed [msl_pkg::ACC_W-1:0]              i_accel_x,
    input  wire logic signed [msl_pkg::ACC_W-1:0]              i_accel_y,
    output logic signed [msl_pkg::ACC_W+$clog2(WINDOW)-1:0]    o_x_sum,
    output logic signed [msl_pkg::ACC_W+$clog2(WINDOW)-1:0]    o_y_sum
);

    import msl_pkg::*;

    localparam int SUM_W = ACC_W + $clog2(WINDOW);

    logic signed [ACC_W-1:0] r_x_hist [WINDOW];
    logic signed [ACC_W-1:0] r_y_hist [WINDOW];
    logic signed [SUM_W-1:0] r_x_sum;
    logic signed [SUM_W-1:0] r_y_sum;
    logic signed [SUM_W-1:0] n_x_sum;
    logic signed [SUM_W-1:0] n_y_sum;
    logic [CNT_W-1:0]        r_samp_cnt;
    logic [CNT_W-1:0]        n_samp_cnt;
    logic [CNT_W-1:0]        w_samp_inc;
    logic                    w_samp_fire;
    logic signed [SUM_W:0]   w_x_acc;
    logic signed [SUM_W:0]   w_y_acc;

    assign w_samp_inc  = sat_inc(r_samp_cnt);
    assign w_samp_fire = (w_samp_inc >= i_cfg.sample_per);
    assign n_samp_cnt  = w_samp_fire ? '0 : w_samp_inc;

    // oldest sample sits at the far end of the shift line
    assign w_x_acc = (SUM_W+1)'(r_x_sum) - (SUM_W+1)'(r_x_hist[WINDOW-1])
                     + (SUM_W+1)'(i_accel_x);
    assign w_y_acc = (SUM_W+1)'(r_y_sum) - (SUM_W+1)'(r_y_hist[WINDOW-1])
                     + (SUM_W+1)'(i_accel_y);

    assign n_x_sum = w_samp_fire ? w_x_acc[SUM_W-1:0] : r_x_sum;
    assign n_y_sum = w_samp_fire ? w_y_acc[SUM_W-1:0] : r_y_sum;

    assign o_x_sum = n_x_sum;
    assign o_y_sum = n_y_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samp_cnt <= CNT_SAT;
            r_x_sum    <= '0;
            r_y_sum    <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                r_x_hist[i] <= '0;
                r_y_hist[i] <= '0;
            end
        end else if (i_step) begin
            r_samp_cnt <= n_samp_cnt;
            r_x_sum    <= n_x_sum;
            r_y_sum    <= n_y_sum;
            if (w_samp_fire) begin
                r_x_hist[0] <= i_accel_x;
                r_y_hist[0] <= i_accel_y;
                for (int i = 1; i < WINDOW; i++) begin
                    r_x_hist[i] <= r_x_hist[i-1];
                    r_y_hist[i] <= r_y_hist[i-1];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/msl_signal.sv =====
// ---------------------------------------------------------------------------
// msl_signal
// turn and brake decisions, blinker, brake ramp and held led colour
// ---------------------------------------------------------------------------
`default_nettype none

module msl_signal #(
    parameter int WINDOW = 20
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_step,
    input  wire msl_pkg::t_cfg                                 i_cfg,
    input  wire logic signed [msl_pkg::ACC_W+$clog2(WINDOW)-1:0] i_x_sum,
    input  wire logic signed [msl_pkg::ACC_W+$clog2(WINDOW)-1:0] i_y_sum,
    input  wire logic                                          i_button,
    output msl_pkg::t_result                                   o_res
);

    import msl_pkg::*;

    localparam int SUM_W = ACC_W + $clog2(WINDOW);
    localparam int LIM_W = SUM_W + 1;
    localparam logic signed [LIM_W-1:0] WIN_S = LIM_W'(WINDOW);

    logic [CNT_W-1:0]        r_blink_cnt;
    logic [CNT_W-1:0]        n_blink_cnt;
    logic [CNT_W-1:0]        r_ramp_cnt;
    logic [CNT_W-1:0]        n_ramp_cnt;
    logic                    r_turning;
    logic                    n_turning;
    logic                    r_lit;
    logic                    n_lit;
    logic [LVL_W-1:0]        r_level;
    logic [LVL_W-1:0]        n_level;
    logic                    r_rising;
    logic                    n_rising;
    logic [COLOUR_W-1:0]     r_colour;
    logic [COLOUR_W-1:0]     n_colour;

    logic [CNT_W-1:0]        w_blink_inc;
    logic [CNT_W-1:0]        w_ramp_inc;
    logic                    w_blink_fire;
    logic                    w_ramp_fire;
    logic signed [LIM_W-1:0] w_turn_lim;
    logic signed [LIM_W-1:0] w_brake_lim;
    logic signed [LIM_W-1:0] w_y;
    logic signed [LIM_W-1:0] w_x;
    logic                    w_over;
    logic                    w_under;
    logic                    w_braking;
    logic                    w_rise_a;
    logic                    w_rise_b;

    // thresholds scaled to the sum domain instead of dividing the sums
    assign w_turn_lim  = LIM_W'(signed'({1'b0, i_cfg.turn_thr})) * WIN_S;
    assign w_brake_lim = LIM_W'(i_cfg.brake_thr) * WIN_S;
    assign w_y = LIM_W'(i_y_sum);
    assign w_x = LIM_W'(i_x_sum);

    assign w_over    = (w_y > w_turn_lim) || (w_y < -w_turn_lim);
    assign w_under   = (w_y < w_turn_lim) && (w_y > -w_turn_lim);
    assign n_turning = w_over ? 1'b1 : (w_under ? 1'b0 : r_turning);
    assign w_braking = (w_x > w_brake_lim);

    assign w_blink_inc  = sat_inc(r_blink_cnt);
    assign w_ramp_inc   = sat_inc(r_ramp_cnt);
    assign w_blink_fire = (w_blink_inc >= i_cfg.blink_per);
    assign w_ramp_fire  = (w_ramp_inc >= i_cfg.ramp_per);

    // direction flips at the top while rising and at zero while falling
    assign w_rise_a = r_rising && (r_level != LVL_MAX);
    assign w_rise_b = w_rise_a || (r_level == '0);

    always_comb begin
        n_blink_cnt = w_blink_inc;
        n_ramp_cnt  = w_ramp_inc;
        n_lit       = r_lit;
        n_level     = r_level;
        n_rising    = r_rising;
        n_colour    = r_colour;

        if (n_turning) begin
            if (w_blink_fire) begin
                n_lit       = !r_lit;
                n_colour    = r_lit ? '0 : ORANGE;
                n_blink_cnt = '0;
            end
        end else begin
            n_lit = 1'b0;
        end

        // ramp step lands after the blink and wins the colour
        if (w_braking && w_ramp_fire) begin
            n_rising   = w_rise_b;
            n_level    = w_rise_b ? r_level + RAMP_STEP : r_level - RAMP_STEP;
            n_colour   = {n_level, 16'h0000};
            n_ramp_cnt = '0;
        end

        if (!w_braking && !n_turning) begin
            n_colour = '0;
        end
    end

    always_comb begin
        o_res.led_red     = n_colour[23:16];
        o_res.led_green   = n_colour[15:8];
        o_res.led_blue    = n_colour[7:0];
        o_res.front_light = !n_turning && !w_braking && i_button;
        o_res.is_turning  = n_turning;
        o_res.is_braking  = w_braking;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_cnt <= CNT_SAT;
            r_ramp_cnt  <= CNT_SAT;
            r_turning   <= 1'b0;
            r_lit       <= 1'b0;
            r_level     <= '0;
            r_rising    <= 1'b1;
            r_colour    <= '0;
        end else if (i_step) begin
            r_blink_cnt <= n_blink_cnt;
            r_ramp_cnt  <= n_ramp_cnt;
            r_turning   <= n_turning;
            r_lit       <= n_lit;
            r_level     <= n_level;
            r_rising    <= n_rising;
            r_colour    <= n_colour;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/motion_signal_light_controller_unit.sv =====
// ---------------------------------------------------------------------------
// motion signal light controller unit
// turn blinker, brake ramp and front light driven by averaged acceleration
// ---------------------------------------------------------------------------
//
//  channel   direction  contents                                   handshake
//  i_in      in         accel_x, accel_y, button_pressed           valid/ready
//  o_out     out        led_red/green/blue, front_light,           valid/ready
//                       is_turning, is_braking
//  i_cfg_*   in         register index and write data              write enable
//
//  one request per clock sustained while o_out.ready stays high: a request lands
//  in the input register, is worked in one pass of adds and compares and lands in
//  the result register, so each result passes both registers in that order
//  the input register, when empty, accepts a new request while a finished result waits
//  reset is synchronous, active low; no clearing pass, the request side is
//  ready in the first cycle after reset
//  a stalled result holds the input register, and i_in.ready drops only when
//  both registers are full
//
`default_nettype none

`include "motion_signal_light_controller_unit_defines.svh"

module motion_signal_light_controller_unit #(
    parameter int WINDOW = 20
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [msl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [msl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    msl_in_if.sink                                 i_in,
    msl_out_if.source                              o_out
);

    import msl_pkg::*;

    localparam int SUM_W = ACC_W + $clog2(WINDOW);

    // configuration registers
    t_cfg r_cfg;

    // input register
    logic                    r_in_valid;
    logic signed [ACC_W-1:0] r_in_x;
    logic signed [ACC_W-1:0] r_in_y;
    logic                    r_in_btn;

    // result register
    logic                    r_out_valid;
    t_result                 r_out;

    logic                    w_step;
    logic                    w_in_take;
    logic signed [SUM_W-1:0] w_x_sum;
    logic signed [SUM_W-1:0] w_y_sum;
    t_result                 w_res;

    // the held request moves on when the result register is empty or drains
    assign w_step    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_step;
    assign w_in_take = i_in.valid && i_in.ready;

    // register writes, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.turn_thr   <= TURN_RST;
            r_cfg.brake_thr  <= BRAKE_RST;
            r_cfg.sample_per <= SAMPLE_RST;
            r_cfg.blink_per  <= BLINK_RST;
            r_cfg.ramp_per   <= RAMP_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_TURN:   r_cfg.turn_thr   <= i_cfg_data[TURN_W-1:0];
                REG_BRAKE:  r_cfg.brake_thr  <= signed'(i_cfg_data);
                REG_SAMPLE: r_cfg.sample_per <= i_cfg_data;
                REG_BLINK:  r_cfg.blink_per  <= i_cfg_data;
                REG_RAMP:   r_cfg.ramp_per   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_x   <= i_in.accel_x;
            r_in_y   <= i_in.accel_y;
            r_in_btn <= i_in.button_pressed;
        end
    end

    // moving sums, updated by the sample timer
    msl_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_cfg     (r_cfg),
        .i_accel_x (r_in_x),
        .i_accel_y (r_in_y),
        .o_x_sum   (w_x_sum),
        .o_y_sum   (w_y_sum)
    );

    // decisions and light state from this tick's sums
    msl_signal #(
        .WINDOW (WINDOW)
    ) u_signal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_cfg    (r_cfg),
        .i_x_sum  (w_x_sum),
        .i_y_sum  (w_y_sum),
        .i_button (r_in_btn),
        .o_res    (w_res)
    );

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.led_red     = r_out.led_red;
    assign o_out.led_green   = r_out.led_green;
    assign o_out.led_blue    = r_out.led_blue;
    assign o_out.front_light = r_out.front_light;
    assign o_out.is_turning  = r_out.is_turning;
    assign o_out.is_braking  = r_out.is_braking;

    // checks

    // an empty result register never blocks the request side
    `MSL_ASSERT(a_ready_when_empty, !r_out_valid |-> i_in.ready)

    // a new result only comes from a held request
    `MSL_ASSERT(a_result_has_source, $rose(r_out_valid) |-> $past(r_in_valid))

    // front light stays off while any signal light runs
    `MSL_ASSERT_MSG(a_front_exclusive,
        r_out_valid |-> !(r_out.front_light && (r_out.is_turning || r_out.is_braking)),
        "front light on during turn or brake")

    // led black when neither turning nor braking
    `MSL_ASSERT_MSG(a_idle_black,
        (r_out_valid && !r_out.is_turning && !r_out.is_braking)
            |-> (r_out.led_red == '0 && r_out.led_green == '0 && r_out.led_blue == '0),
        "led lit while idle")

endmodule

`default_nettype wire

// ===== tb/msl_light_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// msl_light_checker
// follows every accepted tick, predicts the light state it leads to and
// compares each accepted result with the oldest prediction, field by field
// ---------------------------------------------------------------------------

module msl_light_checker #(
    parameter int WINDOW = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [msl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [msl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    msl_in_if                              i_in,
    msl_out_if                             i_out,
    output int                             o_pending,
    output int                             o_fail_count,
    output int                             o_checked,
    output int                             o_turn_seen,
    output int                             o_brake_seen
);

    import msl_pkg::*;

    localparam logic [COLOUR_W-1:0] AMBER    = 24'hFF4100;
    localparam logic [LVL_W-1:0]    RAMP_INC = 8'd15;

    // register copy
    logic [TURN_W-1:0]       turn_thr;
    logic signed [ACC_W-1:0] brake_thr;
    logic [CNT_W-1:0]        sample_per;
    logic [CNT_W-1:0]        blink_per;
    logic [CNT_W-1:0]        ramp_per;

    // light state
    logic signed [ACC_W-1:0] x_hist [WINDOW];
    logic signed [ACC_W-1:0] y_hist [WINDOW];
    int                      slot;
    int                      x_sum;
    int                      y_sum;
    logic [CNT_W-1:0]        sample_cnt;
    logic [CNT_W-1:0]        blink_cnt;
    logic [CNT_W-1:0]        ramp_cnt;
    logic                    turning;
    logic                    blink_on;
    logic                    ramp_up;
    logic [LVL_W-1:0]        ramp_lvl;
    logic [COLOUR_W-1:0]     colour;

    t_result expected_lights [$];
    int      fails;
    int      checked;
    int      turn_seen;
    int      brake_seen;

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic void check_field(input string what, input logic [LVL_W-1:0] want,
                                        input logic [LVL_W-1:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
        end
    endfunction

    // one millisecond tick of the controller
    function automatic t_result next_light_state(input logic signed [ACC_W-1:0] ax,
                                                 input logic signed [ACC_W-1:0] ay,
                                                 input logic btn);
        t_result r;
        longint  band;
        longint  ys;
        logic    braking;
        sample_cnt = count_up(sample_cnt);
        blink_cnt  = count_up(blink_cnt);
        ramp_cnt   = count_up(ramp_cnt);

        if (sample_cnt >= sample_per) begin
            x_sum        = x_sum - int'(x_hist[slot]) + int'(ax);
            y_sum        = y_sum - int'(y_hist[slot]) + int'(ay);
            x_hist[slot] = ax;
            y_hist[slot] = ay;
            slot         = (slot + 1 >= WINDOW) ? 0 : slot + 1;
            sample_cnt   = '0;
        end

        // sums are compared against threshold times window, no division
        band = longint'(turn_thr) * WINDOW;
        ys   = longint'(y_sum);
        if (ys > band || ys < -band)
            turning = 1'b1;
        else if (ys < band && ys > -band)
            turning = 1'b0;

        if (turning) begin
            if (blink_cnt >= blink_per) begin
                colour    = blink_on ? '0 : AMBER;
                blink_on  = !blink_on;
                blink_cnt = '0;
            end
        end else begin
            blink_on = 1'b0;
        end

        // ramp step comes after the blink and wins on a shared tick
        braking = longint'(x_sum) > longint'(brake_thr) * WINDOW;
        if (braking && ramp_cnt >= ramp_per) begin
            if (ramp_lvl == LVL_MAX && ramp_up)
                ramp_up = 1'b0;
            if (ramp_lvl == '0 && !ramp_up)
                ramp_up = 1'b1;
            ramp_lvl = ramp_up ? ramp_lvl + RAMP_INC : ramp_lvl - RAMP_INC;
            colour   = {ramp_lvl, 16'h0000};
            ramp_cnt = '0;
        end

        if (!braking && !turning)
            colour = '0;

        r.led_red     = colour[23:16];
        r.led_green   = colour[15:8];
        r.led_blue    = colour[7:0];
        r.front_light = !turning && !braking && btn;
        r.is_turning  = turning;
        r.is_braking  = braking;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            turn_thr   = TURN_RST;
            brake_thr  = BRAKE_RST;
            sample_per = SAMPLE_RST;
            blink_per  = BLINK_RST;
            ramp_per   = RAMP_RST;
            for (int i = 0; i < WINDOW; i++) begin
                x_hist[i] = '0;
                y_hist[i] = '0;
            end
            slot       = 0;
            x_sum      = 0;
            y_sum      = 0;
            sample_cnt = '1;
            blink_cnt  = '1;
            ramp_cnt   = '1;
            turning    = 1'b0;
            blink_on   = 1'b0;
            ramp_lvl   = '0;
            ramp_up    = 1'b1;
            colour     = '0;
            expected_lights.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                checked++;
                if (expected_lights.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none actual %0d/%0d/%0d %b%b%b",
                             $time, i_out.led_red, i_out.led_green, i_out.led_blue,
                             i_out.front_light, i_out.is_turning, i_out.is_braking);
                end else begin
                    want = expected_lights.pop_front();
                    turn_seen  += int'(want.is_turning);
                    brake_seen += int'(want.is_braking);
                    check_field("led_red", want.led_red, i_out.led_red);
                    check_field("led_green", want.led_green, i_out.led_green);
                    check_field("led_blue", want.led_blue, i_out.led_blue);
                    check_field("front_light", LVL_W'(want.front_light),
                                LVL_W'(i_out.front_light));
                    check_field("is_turning", LVL_W'(want.is_turning),
                                LVL_W'(i_out.is_turning));
                    check_field("is_braking", LVL_W'(want.is_braking),
                                LVL_W'(i_out.is_braking));
                end
            end
            if (i_in.valid && i_in.ready)
                expected_lights.push_back(next_light_state(i_in.accel_x, i_in.accel_y,
                                                           i_in.button_pressed));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TURN:   turn_thr   = i_cfg_data[TURN_W-1:0];
                    REG_BRAKE:  brake_thr  = i_cfg_data;
                    REG_SAMPLE: sample_per = i_cfg_data;
                    REG_BLINK:  blink_per  = i_cfg_data;
                    REG_RAMP:   ramp_per   = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_lights.size();
        o_fail_count <= fails;
        o_checked    <= checked;
        o_turn_seen  <= turn_seen;
        o_brake_seen <= brake_seen;
    end

endmodule

// ===== tb/motion_signal_light_controller_unit_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// motion signal light controller unit test
// drives tick requests through a series of register settings, first a short
// directed sequence, then held acceleration levels around the thresholds
// mixed with noise; a checker beside the block predicts every result
// ---------------------------------------------------------------------------

module motion_signal_light_controller_unit_test;

    import msl_pkg::*;

    localparam int WINDOW      = 20;
    localparam int PHASES      = 10;
    localparam int PHASE_TICKS = 53;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  rx_ready = 1'b0;

    // idle percentages of the request and result sides
    int tx_idle_pct = 25;
    int rx_idle_pct = 62;

    int pending;
    int fail_count;
    int checked;
    int turn_seen;
    int brake_seen;
    int ticks_sent;
    int settings_loaded;

    msl_in_if  in_ch ();
    msl_out_if out_ch ();

    assign out_ch.ready = rx_ready;

    motion_signal_light_controller_unit #(
        .WINDOW (WINDOW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    msl_light_checker #(
        .WINDOW (WINDOW)
    ) light_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_checked    (checked),
        .o_turn_seen  (turn_seen),
        .o_brake_seen (brake_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side stalls at random, rate set per phase
    always @(posedge i_clk) begin
        rx_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // one tick request; valid stays high into the next request unless it idles,
    // so valid never gets two assignments in one step
    task automatic send_tick(input logic signed [ACC_W-1:0] ax,
                             input logic signed [ACC_W-1:0] ay, input logic btn);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.accel_x        <= ax;
        in_ch.accel_y        <= ay;
        in_ch.button_pressed <= btn;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        ticks_sent++;
    endtask

    // stop requesting and wait until every predicted result has come back,
    // then let the two stage pipeline settle
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    // all five registers, plus one write past the last index that must be ignored;
    // the unused top bit of the turn threshold carries junk
    task automatic load_settings(input logic [TURN_W-1:0] turn,
                                 input logic signed [ACC_W-1:0] brake,
                                 input logic [CNT_W-1:0] sample,
                                 input logic [CNT_W-1:0] blink,
                                 input logic [CNT_W-1:0] ramp);
        write_reg(REG_TURN, {1'($urandom), turn});
        write_reg(REG_BRAKE, brake);
        write_reg(REG_SAMPLE, sample);
        write_reg(REG_BLINK, blink);
        write_reg(REG_RAMP, ramp);
        write_reg(CFG_IDX_W'(REG_RAMP) + CFG_IDX_W'($urandom_range(1, 3)),
                  CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_loaded++;
    endtask

    // a level close to a threshold: exactly on it, one off, a bit off,
    // anywhere, or zero; clamped to the sensor range
    function automatic logic signed [ACC_W-1:0] near_level(input int centre);
        int v;
        case ($urandom_range(0, 6))
            0:       v = centre;
            1:       v = centre + 1;
            2:       v = centre - 1;
            3:       v = centre + int'($urandom_range(0, 200));
            4:       v = centre - int'($urandom_range(0, 200));
            5:       v = int'($urandom_range(0, 65535)) - 32768;
            default: v = 0;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return ACC_W'(v);
    endfunction

    // mostly held levels long enough to fill the averaging window, so the
    // sums settle right at or around the thresholds; the rest is noise
    task automatic run_phase(input int n_ticks, input logic [TURN_W-1:0] turn,
                             input logic signed [ACC_W-1:0] brake, input bit pause_midway);
        int                      sent;
        int                      left;
        bit                      noisy;
        bit                      steady;
        logic                    btn;
        logic signed [ACC_W-1:0] hx;
        logic signed [ACC_W-1:0] hy;
        sent = 0;
        left = 0;
        noisy = 1'b0;
        steady = 1'b1;
        btn = 1'b0;
        hx = '0;
        hy = '0;
        while (sent < n_ticks) begin
            if (left == 0) begin
                noisy = ($urandom_range(0, 9) >= 7);
                if (noisy) begin
                    left = $urandom_range(1, 6);
                end else begin
                    left   = $urandom_range(8, 40);
                    hy     = near_level($urandom_range(0, 1) ? int'(turn) : -int'(turn));
                    hx     = near_level(int'(brake));
                    steady = 1'($urandom_range(0, 1));
                    btn    = 1'($urandom_range(0, 1));
                end
            end
            btn = btn ^ ($urandom_range(0, 15) == 0);
            if (noisy)
                send_tick(ACC_W'($urandom), ACC_W'($urandom), 1'($urandom));
            else if (steady)
                send_tick(hx, hy, btn);
            else
                send_tick(ACC_W'(int'(hx) + int'($urandom_range(0, 4)) - 2),
                          ACC_W'(int'(hy) + int'($urandom_range(0, 4)) - 2), btn);
            left--;
            sent++;
            // hold off new requests until the block has caught up
            if (pause_midway && sent == n_ticks / 2)
                drain_results();
        end
    endtask

    initial begin
        logic [TURN_W-1:0]       turn;
        logic signed [ACC_W-1:0] brake;
        logic [CNT_W-1:0]        sample;
        logic [CNT_W-1:0]        blink;
        logic [CNT_W-1:0]        ramp;

        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= '0;
        cfg_data             <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.accel_x        <= '0;
        in_ch.accel_y        <= '0;
        in_ch.button_pressed <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: the first tick has all timers due; it samples, but neither turns nor brakes
        send_tick(16'sh7FFF, 16'sh8000, 1'b1);
        send_tick(16'sh8000, 16'sh7FFF, 1'b0);
        send_tick(16'sh0000, 16'sh0000, 1'b1);
        drain_results();

        // directed sequence: sample every tick (zero period), band of 100
        // so the y sum edge is 2000; the window still holds the first sample
        // above (x full positive, y full negative) until this sequence ends
        load_settings(15'd100, 16'sd100, 16'd0, 16'd1, 16'd0);
        send_tick(16'sh0000, 16'sh0000, 1'b1);
        send_tick(16'sh0000, 16'sh0000, 1'b0);
        send_tick(16'sh7FFF, 16'sh0000, 1'b1);
        send_tick(16'sh8000, 16'sh0000, 1'b1);
        send_tick(16'sh0000, 16'sd2000, 1'b1);
        send_tick(16'sh0000, 16'sd1, 1'b1);
        send_tick(16'sh0000, 16'shFFFF, 1'b0);
        send_tick(16'sh0000, 16'shFFFF, 1'b0);
        send_tick(16'sh0000, 16'sh8000, 1'b1);
        send_tick(16'sh7FFF, 16'sh0000, 1'b1);
        send_tick(16'sh0000, 16'sh0000, 1'b1);
        send_tick(16'sh0000, 16'sh0000, 1'b1);
        send_tick(16'sh8000, 16'sh7FFF, 1'b0);
        send_tick(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_tick(16'sh7FFF, 16'sh8000, 1'b0);
        send_tick(16'shFFFF, 16'shFFFF, 1'b1);
        send_tick(16'sh0001, 16'sh0001, 1'b0);
        send_tick(16'sh8000, 16'sh8000, 1'b1);
        send_tick(16'sh5555, 16'shAAAA, 1'b0);
        send_tick(16'shAAAA, 16'sh5555, 1'b1);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            // receiver idles most first, then the sender, then neither
            if (p < 3) begin
                tx_idle_pct = 25;
                rx_idle_pct = 62;
            end else if (p < 6) begin
                tx_idle_pct = 62;
                rx_idle_pct = 25;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (p)
                0: begin  // fast everything, low thresholds
                    turn = 15'd100;    brake = 16'sd100;
                    sample = 16'd1;    blink = 16'd1;      ramp = 16'd1;
                end
                1: begin  // zero periods, lowest thresholds: braking almost always
                    turn = 15'd0;      brake = 16'sh8000;
                    sample = 16'd0;    blink = 16'd0;      ramp = 16'd0;
                end
                2: begin  // highest thresholds: braking never, turning only at full scale
                    turn = 15'h7FFF;   brake = 16'sh7FFF;
                    sample = 16'd1;    blink = 16'd2;      ramp = 16'd3;
                end
                3: begin  // reset thresholds with fast timing
                    turn = TURN_RST;   brake = BRAKE_RST;
                    sample = 16'd1;    blink = 16'd7;      ramp = 16'd1;
                end
                4: begin  // longest periods, timing practically frozen
                    turn = 15'd300;    brake = -16'sd300;
                    sample = 16'hFFFF; blink = 16'hFFFF;   ramp = 16'hFFFF;
                end
                default: begin
                    turn   = TURN_W'($urandom_range(0, 2000));
                    brake  = ACC_W'(int'($urandom_range(0, 4000)) - 2000);
                    sample = CNT_W'($urandom_range(1, 3));
                    blink  = CNT_W'($urandom_range(1, 6));
                    ramp   = CNT_W'($urandom_range(1, 4));
                end
            endcase
            load_settings(turn, brake, sample, blink, ramp);
            run_phase(PHASE_TICKS, turn, brake, p == 5);
            drain_results();
        end

        $display("sent %0d ticks under %0d register settings, %0d results checked",
                 ticks_sent, settings_loaded, checked);
        $display("turning shown in %0d results, braking in %0d", turn_seen, brake_seen);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/msl_pkg.sv
rtl/core/msl_in_if.sv
rtl/core/msl_out_if.sv
rtl/core/msl_window.sv
rtl/core/msl_signal.sv
rtl/core/motion_signal_light_controller_unit.sv
tb/msl_light_checker.sv
tb/motion_signal_light_controller_unit_test.sv
